// ===== rtl/pidc_pkg.sv =====
// pidc_pkg: widths, register indexes, configuration record and shared helpers
// for the PID controller block. No dependencies.
package pidc_pkg;

	localparam int FRAC_BITS = 16;

	localparam int DATA_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int BOUND_W  = 16;
	localparam int SAMPLE_W = 16;
	localparam int DBAND_W  = 31;
	localparam int IDX_W    = 3;

	localparam int ERR_W    = DATA_W + 1;
	localparam int INT_W    = 48;
	localparam int DER_W    = ERR_W + 1;
	localparam int INT_LO_W = 16;
	localparam int INT_HI_W = INT_W - INT_LO_W;

	localparam int PE_W  = GAIN_W + ERR_W;
	localparam int PD_W  = GAIN_W + DER_W;
	localparam int PIH_W = GAIN_W + INT_HI_W;
	localparam int PIL_W = GAIN_W + INT_LO_W + 1;
	localparam int KI_W  = GAIN_W + INT_W;
	localparam int SUM_W = KI_W + 2;
	localparam int WIDE_W = 64;

	localparam logic signed [WIDE_W-1:0] S64_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] S64_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
	localparam logic signed [WIDE_W-1:0] S32_MAX =
		WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [WIDE_W-1:0] S32_MIN =
		{{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_OUT_MAX,
		REG_OUT_MIN,
		REG_SAMPLE_MS,
		REG_DEADBAND,
		REG_TARGET
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
		logic [GAIN_W-1:0]   kd;
		logic [BOUND_W-1:0]  out_max;
		logic [BOUND_W-1:0]  out_min;
		logic [SAMPLE_W-1:0] sample_ms;
		logic [DBAND_W-1:0]  deadband;
		logic [DATA_W-1:0]   target;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		kp:        '0,
		ki:        '0,
		kd:        '0,
		out_max:   16'd360,
		out_min:   '0,
		sample_ms: 16'd1000,
		deadband:  31'd3277,
		target:    '0
	};

	// error, updated integral and derivative of one controller run
	typedef struct packed {
		logic [ERR_W-1:0] err;
		logic [INT_W-1:0] integ;
		logic [DER_W-1:0] deriv;
	} front_t;

	// whole-unit clamp bound scaled to the fixed-point grid
	function automatic logic signed [WIDE_W-1:0] bound_q(input logic [BOUND_W-1:0] b);
		logic signed [WIDE_W-1:0] ext;
		ext = WIDE_W'($signed(b));
		return ext <<< FRAC_BITS;
	endfunction

endpackage

// ===== rtl/pidc_item_if.sv =====
// pidc_item_if: valid/ready channel carrying one tick or sample beat.
// Depends on pidc_pkg.
interface pidc_item_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [pidc_pkg::DATA_W-1:0]  measured;

	modport source (output valid, output operation, output measured, input ready);
	modport sink (input valid, input operation, input measured, output ready);
endinterface

// ===== rtl/pidc_result_if.sv =====
// pidc_result_if: valid/ready channel carrying one controller output beat.
// Depends on pidc_pkg.
interface pidc_result_if;
	logic                         valid;
	logic                         ready;
	logic [pidc_pkg::DATA_W-1:0]  drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

// ===== rtl/pid_controller_deadband_clamp.sv =====
// pid_controller_deadband_clamp: discrete PID step on signed Q16.16 with deadband.
// Throughput: one beat per cycle unless the result channel stalls; ticks and early samples give no result.
// After the input register a beat passes five registers (state, products, two adder levels, clamp).
// Reset (arst_n low): pipeline empty, timer/integral/last error zero, registers at defaults.
// Depends on pidc_pkg, pidc_item_if, pidc_result_if and the pidc_* stages.
module pid_controller_deadband_clamp (
	input  logic                        clk,
	input  logic                        arst_n,
	pidc_item_if.sink                   item,
	pidc_result_if.source               result,
	input  logic                        cfg_we,
	input  logic [pidc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pidc_pkg::DATA_W-1:0] cfg_data
);
	import pidc_pkg::*;

	cfg_t                cfg;
	logic                fr_valid;
	front_t              fr_data;
	logic                mac_ready;
	logic                mac_valid;
	logic [SUM_W-1:0]    mac_sum;
	logic                clamp_ready;
	logic signed [WIDE_W-1:0] hi_b;
	logic signed [WIDE_W-1:0] lo_b;

	pidc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	pidc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (item.valid),
		.in_operation (item.operation),
		.in_measured  (item.measured),
		.in_ready     (item.ready),
		.dn_valid     (fr_valid),
		.dn_data      (fr_data),
		.dn_ready     (mac_ready)
	);

	pidc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (fr_valid),
		.up_data  (fr_data),
		.up_ready (mac_ready),
		.dn_valid (mac_valid),
		.dn_sum   (mac_sum),
		.dn_ready (clamp_ready)
	);

	pidc_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (mac_valid),
		.up_sum    (mac_sum),
		.up_ready  (clamp_ready),
		.out_valid (result.valid),
		.out_drive (result.drive),
		.out_ready (result.ready)
	);

	assign hi_b = bound_q(cfg.out_max);
	assign lo_b = bound_q(cfg.out_min);

	// input stalls only when the run register is full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (fr_valid && !mac_ready))
		else $error("item channel stalled with room downstream");

	// a result beat appears only after a sum was waiting
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(mac_valid))
		else $error("result beat without a computed sum");

	// with ordered bounds inside 32 bits the drive lies between them
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && lo_b <= hi_b && lo_b >= S32_MIN && hi_b <= S32_MAX) |->
		(WIDE_W'($signed(result.drive)) >= lo_b && WIDE_W'($signed(result.drive)) <= hi_b))
		else $error("drive outside clamp bounds");

endmodule

// ===== rtl/pidc_cfg_regs.sv =====
// pidc_cfg_regs: configuration register file written through the plain write port.
// Depends on pidc_pkg.
module pidc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [pidc_pkg::IDX_W-1:0]  index,
	input  logic [pidc_pkg::DATA_W-1:0] data,
	output pidc_pkg::cfg_t              cfg
);
	import pidc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_KP:        cfg_q.kp        <= data[GAIN_W-1:0];
				REG_KI:        cfg_q.ki        <= data[GAIN_W-1:0];
				REG_KD:        cfg_q.kd        <= data[GAIN_W-1:0];
				REG_OUT_MAX:   cfg_q.out_max   <= data[BOUND_W-1:0];
				REG_OUT_MIN:   cfg_q.out_min   <= data[BOUND_W-1:0];
				REG_SAMPLE_MS: cfg_q.sample_ms <= data[SAMPLE_W-1:0];
				REG_DEADBAND:  cfg_q.deadband  <= data[DBAND_W-1:0];
				REG_TARGET:    cfg_q.target    <= data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pidc_front.sv =====
// pidc_front: input register, sample gating and controller state (timer,
// integral, last error). Emits one record per run. Depends on pidc_pkg.
module pidc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pidc_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	input  logic                        in_operation,
	input  logic [pidc_pkg::DATA_W-1:0] in_measured,
	output logic                        in_ready,
	output logic                        dn_valid,
	output pidc_pkg::front_t            dn_data,
	input  logic                        dn_ready
);
	import pidc_pkg::*;

	logic                     v_s1;
	logic                     op_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic                     v_s2;
	front_t                   data_s2;

	logic signed [INT_W-1:0]  integ_q;
	logic signed [ERR_W-1:0]  prev_q;
	logic [SAMPLE_W-1:0]      elapsed_q;

	logic                     load_s2;
	logic                     run;
	logic                     above;
	logic [ERR_W-1:0]         mag;
	logic signed [INT_W:0]    isum;
	logic signed [INT_W-1:0]  integ_nxt;
	logic signed [ERR_W-1:0]  err_in;

	assign load_s2  = !v_s2 || dn_ready;
	assign in_ready = !v_s1 || load_s2;
	assign err_in   = ERR_W'($signed(cfg.target)) - ERR_W'($signed(in_measured));

	always_comb begin
		run   = (op_s1 == OP_SAMPLE) && (elapsed_q >= cfg.sample_ms);
		mag   = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);
		above = mag > ERR_W'(cfg.deadband);
		isum  = (INT_W+1)'(integ_q) + (INT_W+1)'(err_s1);
		if (!above) begin
			integ_nxt = integ_q;
		end else if (isum[INT_W] != isum[INT_W-1]) begin
			integ_nxt = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
			                        : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			integ_nxt = isum[INT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= in_operation;
			err_s1 <= err_in;
		end
	end

	// state moves once, when the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			prev_q    <= '0;
			elapsed_q <= '0;
		end else if (v_s1 && load_s2) begin
			if (op_s1 == OP_TICK) begin
				if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + SAMPLE_W'(1);
				end
			end else if (run) begin
				elapsed_q <= '0;
				integ_q   <= integ_nxt;
				prev_q    <= err_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= v_s1 && run;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && v_s1 && run) begin
			data_s2.err   <= err_s1;
			data_s2.integ <= integ_nxt;
			data_s2.deriv <= DER_W'(err_s1) - DER_W'(prev_q);
		end
	end

	assign dn_valid = v_s2;
	assign dn_data  = data_s2;

endmodule

// ===== rtl/pidc_mac.sv =====
// pidc_mac: gain products and their scaled sum over three stages.
// Integral product is split into two partial products. Depends on pidc_pkg.
module pidc_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pidc_pkg::cfg_t              cfg,
	input  logic                        up_valid,
	input  pidc_pkg::front_t            up_data,
	output logic                        up_ready,
	output logic                        dn_valid,
	output logic [pidc_pkg::SUM_W-1:0]  dn_sum,
	input  logic                        dn_ready
);
	import pidc_pkg::*;

	logic                     v_s3, v_s4, v_s5;
	logic                     load_s3, load_s4, load_s5;

	logic signed [PE_W-1:0]   pe_s3;
	logic signed [PD_W-1:0]   pd_s3;
	logic signed [PIH_W-1:0]  pih_s3;
	logic signed [PIL_W-1:0]  pil_s3;

	logic signed [SUM_W-1:0]  pp_s4;
	logic signed [SUM_W-1:0]  ki_s4;
	logic signed [SUM_W-1:0]  sum_s5;

	logic signed [KI_W-1:0]   ki_full;
	logic signed [KI_W-1:0]   ki_shr;
	logic signed [PE_W-1:0]   pe_shr;
	logic signed [PD_W-1:0]   pd_shr;

	assign load_s5  = !v_s5 || dn_ready;
	assign load_s4  = !v_s4 || load_s5;
	assign load_s3  = !v_s3 || load_s4;
	assign up_ready = load_s3;

	always_comb begin
		ki_full = (KI_W'(pih_s3) <<< INT_LO_W) + KI_W'(pil_s3);
		ki_shr  = ki_full >>> FRAC_BITS;
		pe_shr  = pe_s3 >>> FRAC_BITS;
		pd_shr  = pd_s3 >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (load_s3) v_s3 <= up_valid;
			if (load_s4) v_s4 <= v_s3;
			if (load_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && up_valid) begin
			pe_s3  <= $signed(cfg.kp) * $signed(up_data.err);
			pd_s3  <= $signed(cfg.kd) * $signed(up_data.deriv);
			pih_s3 <= $signed(cfg.ki) * $signed(up_data.integ[INT_W-1:INT_LO_W]);
			pil_s3 <= $signed(cfg.ki) * $signed({1'b0, up_data.integ[INT_LO_W-1:0]});
		end
		if (load_s4 && v_s3) begin
			pp_s4 <= SUM_W'(pe_shr) + SUM_W'(pd_shr);
			ki_s4 <= SUM_W'(ki_shr);
		end
		if (load_s5 && v_s4) begin
			sum_s5 <= pp_s4 + ki_s4;
		end
	end

	assign dn_valid = v_s5;
	assign dn_sum   = sum_s5;

endmodule

// ===== rtl/pidc_clamp.sv =====
// pidc_clamp: saturation, output clamp and the output register.
// Depends on pidc_pkg.
module pidc_clamp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pidc_pkg::cfg_t              cfg,
	input  logic                        up_valid,
	input  logic [pidc_pkg::SUM_W-1:0]  up_sum,
	output logic                        up_ready,
	output logic                        out_valid,
	output logic [pidc_pkg::DATA_W-1:0] out_drive,
	input  logic                        out_ready
);
	import pidc_pkg::*;

	logic                      valid_q;
	logic [DATA_W-1:0]         drive_q;
	logic                      load;
	logic signed [WIDE_W-1:0]  s64;
	logic signed [WIDE_W-1:0]  hi_b;
	logic signed [WIDE_W-1:0]  lo_b;
	logic signed [WIDE_W-1:0]  c_hi;
	logic signed [WIDE_W-1:0]  c_lo;
	logic signed [WIDE_W-1:0]  c_32;

	assign load     = !valid_q || out_ready;
	assign up_ready = load;

	always_comb begin
		hi_b = bound_q(cfg.out_max);
		lo_b = bound_q(cfg.out_min);
		if ((&up_sum[SUM_W-1:WIDE_W-1]) || !(|up_sum[SUM_W-1:WIDE_W-1])) begin
			s64 = up_sum[WIDE_W-1:0];
		end else begin
			s64 = up_sum[SUM_W-1] ? S64_MIN : S64_MAX;
		end
		// upper bound first, lower bound wins when they cross
		c_hi = (s64 > hi_b) ? hi_b : s64;
		c_lo = (c_hi < lo_b) ? lo_b : c_hi;
		if (c_lo > S32_MAX) begin
			c_32 = S32_MAX;
		end else if (c_lo < S32_MIN) begin
			c_32 = S32_MIN;
		end else begin
			c_32 = c_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			drive_q <= c_32[DATA_W-1:0];
		end
	end

	assign out_valid = valid_q;
	assign out_drive = drive_q;

endmodule
